@@ rtl/ps2_mouse_packet_decoder_core_macros.svh @@
// Assertion helpers used by the assertions in the core file.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef PS2_MOUSE_PACKET_DECODER_CORE_MACROS_SVH
`define PS2_MOUSE_PACKET_DECODER_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define PS2MD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define PS2MD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ps2md_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ps2md_pkg;

  // Byte positions within a packet
  localparam logic [1:0] POS_HEADER = 2'd0;
  localparam logic [1:0] POS_X      = 2'd1;
  localparam logic [1:0] POS_Y      = 2'd2;
  localparam logic [1:0] POS_EXTRA  = 2'd3;

  // Packet kind reported for an ordinary movement packet
  localparam logic [4:0] KIND_STANDARD = 5'd16;
  // Extended type that carries a wheel delta
  localparam logic [3:0] EXT_TYPE_WHEEL = 4'd1;

  // Extended-packet signature: header bits that must be set
  localparam logic [7:0] SIG_HEADER_MASK = 8'h48;
  // Extended-packet signature: low two bits of the X byte
  localparam logic [1:0] SIG_X_LOW = 2'b10;

  // One framed packet as handed from the framer to the decoder
  typedef struct packed {
    logic [7:0] header;
    logic [7:0] x;
    logic [7:0] y;
  } packet_t;

  // One decoded result word
  typedef struct packed {
    logic [4:0]         packet_kind;
    logic signed [3:0]  wheel_delta;
    logic signed [8:0]  delta_x;
    logic signed [8:0]  delta_y;
    logic [2:0]         button_bits;
    logic [2:0]         error_bits;
    logic signed [8:0]  x_minimum;
    logic [7:0]         x_maximum;
    logic signed [8:0]  y_minimum;
    logic [7:0]         y_maximum;
    logic signed [31:0] x_total;
    logic signed [31:0] y_total;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/ps2md_framer.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ps2md_framer (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              four_byte_packets,
  input  wire logic              byte_valid,
  output logic                   byte_ready,
  input  wire logic [7:0]        data_byte,
  output logic                   pkt_valid,
  input  wire logic              pkt_ready,
  output ps2md_pkg::packet_t     pkt
);

  logic [1:0] byte_position;
  logic [1:0] byte_position_next;
  logic [7:0] header_byte;
  logic [7:0] x_byte;
  logic [7:0] y_byte;
  logic       accept;
  logic       last;

  // Take a byte whenever the packet register is free or draining
  assign byte_ready = !pkt_valid || pkt_ready;
  assign accept     = byte_valid && byte_ready;

  // Advance the position and spot the closing byte
  always_comb begin
    byte_position_next = byte_position;
    last               = 1'b0;
    case (byte_position)
      ps2md_pkg::POS_HEADER: byte_position_next = ps2md_pkg::POS_X;
      ps2md_pkg::POS_X:      byte_position_next = ps2md_pkg::POS_Y;
      ps2md_pkg::POS_Y: begin
        if (four_byte_packets) begin
          byte_position_next = ps2md_pkg::POS_EXTRA;
        end else begin
          byte_position_next = ps2md_pkg::POS_HEADER;
          last               = 1'b1;
        end
      end
      default: begin
        byte_position_next = ps2md_pkg::POS_HEADER;
        last               = 1'b1;
      end
    endcase
  end

  // Track position and packet-register occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= ps2md_pkg::POS_HEADER;
      pkt_valid     <= 1'b0;
    end else begin
      if (accept) begin
        byte_position <= byte_position_next;
      end
      if (accept && last) begin
        pkt_valid <= 1'b1;
      end else if (pkt_ready) begin
        pkt_valid <= 1'b0;
      end
    end
  end

  // Hold the packet bytes; the fourth byte is dropped
  always_ff @(posedge clk) begin
    if (accept) begin
      case (byte_position)
        ps2md_pkg::POS_HEADER: header_byte <= data_byte;
        ps2md_pkg::POS_X:      x_byte      <= data_byte;
        ps2md_pkg::POS_Y:      y_byte      <= data_byte;
        default: ;
      endcase
      if (last) begin
        pkt.header <= header_byte;
        pkt.x      <= x_byte;
        pkt.y      <= (byte_position == ps2md_pkg::POS_Y) ? data_byte : y_byte;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/ps2md_decode.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ps2md_decode (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                pkt_valid,
  output logic                     pkt_ready,
  input  wire ps2md_pkg::packet_t  pkt,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output ps2md_pkg::result_t       res
);

  logic signed [8:0]  min_x;
  logic signed [8:0]  max_x;
  logic signed [8:0]  min_y;
  logic signed [8:0]  max_y;
  logic signed [31:0] sum_x;
  logic signed [31:0] sum_y;

  logic signed [8:0]  min_x_next;
  logic signed [8:0]  max_x_next;
  logic signed [8:0]  min_y_next;
  logic signed [8:0]  max_y_next;
  logic signed [31:0] sum_x_next;
  logic signed [31:0] sum_y_next;

  logic signed [8:0]  dx;
  logic signed [8:0]  dy;
  logic               ext;
  logic [3:0]         ext_type;
  logic               load;

  // Add a 9-bit delta to a total, sticking at the 32-bit range limits
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] acc,
                                                 input logic signed [8:0]  d);
    logic signed [32:0] s;
    s = {acc[31], acc} + {{24{d[8]}}, d};
    if (s[32] != s[31]) begin
      sat_add = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat_add = s[31:0];
    end
  endfunction

  // Load the result register when it is empty or being drained
  assign pkt_ready = !res_valid || res_ready;
  assign load      = pkt_valid && pkt_ready;

  // Sign-extend the deltas with the header sign bits
  assign dx = {pkt.header[4], pkt.x};
  assign dy = {pkt.header[5], pkt.y};

  // Extended-packet signature test
  assign ext = ((pkt.header & ps2md_pkg::SIG_HEADER_MASK) == ps2md_pkg::SIG_HEADER_MASK)
            && (pkt.x[1:0] == ps2md_pkg::SIG_X_LOW)
            && (pkt.x[7] == pkt.x[6])
            && (pkt.x[7] != pkt.header[4])
            && (pkt.x[3:2] == pkt.y[1:0]);
  assign ext_type = {pkt.header[5:4], pkt.x[5:4]};

  // Update running extremes and totals
  always_comb begin
    min_x_next = (dx < min_x) ? dx : min_x;
    max_x_next = (dx > max_x) ? dx : max_x;
    min_y_next = (dy < min_y) ? dy : min_y;
    max_y_next = (dy > max_y) ? dy : max_y;
    sum_x_next = sat_add(sum_x, dx);
    sum_y_next = sat_add(sum_y, dy);
  end

  // Statistics and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      min_x     <= '0;
      max_x     <= '0;
      min_y     <= '0;
      max_y     <= '0;
      sum_x     <= '0;
      sum_y     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (load) begin
        min_x <= min_x_next;
        max_x <= max_x_next;
        min_y <= min_y_next;
        max_y <= max_y_next;
        sum_x <= sum_x_next;
        sum_y <= sum_y_next;
      end
      if (load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (load) begin
      res.delta_x   <= dx;
      res.delta_y   <= dy;
      res.x_minimum <= min_x_next;
      res.x_maximum <= max_x_next[7:0];
      res.y_minimum <= min_y_next;
      res.y_maximum <= max_y_next[7:0];
      res.x_total   <= sum_x_next;
      res.y_total   <= sum_y_next;
      if (ext) begin
        res.packet_kind <= {1'b0, ext_type};
        res.wheel_delta <= (ext_type == ps2md_pkg::EXT_TYPE_WHEEL) ? pkt.y[3:0] : 4'sd0;
        res.button_bits <= 3'd0;
        res.error_bits  <= 3'd0;
      end else begin
        res.packet_kind <= ps2md_pkg::KIND_STANDARD;
        res.wheel_delta <= 4'sd0;
        res.button_bits <= pkt.header[2:0];
        res.error_bits  <= {!pkt.header[3], pkt.header[7], pkt.header[6]};
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/ps2_mouse_packet_decoder_core.sv @@
// A result word is valid on the master side once it has passed the packet
// register, which loads on the edge that accepts the closing byte of a packet,
// and then the result register, which loads when it is empty or being drained.
// Throughput: one byte per cycle; stalls only when both registers are full and held.
// Reset (rst, synchronous, active high): clears the byte position, the running
// statistics, both valid flags, and selects three-byte framing.
`timescale 1ns / 1ps
`default_nettype none

`include "ps2_mouse_packet_decoder_core_macros.svh"

module ps2_mouse_packet_decoder_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_wr_en,
  input  wire logic         cfg_wr_data,   // four_byte_packets
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,  // [7:0] data_byte
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [3:0] wheel_delta, [12:4] delta_x, [21:13] delta_y, [24:22] button_bits,
  // [27:25] error_bits, [36:28] x_minimum, [44:37] x_maximum,
  // [53:45] y_minimum, [61:54] y_maximum, [93:62] x_total,
  // [125:94] y_total, [127:126] zero
  output logic [127:0]      m_axis_tdata,
  output logic [4:0]        m_axis_tuser   // [4:0] packet_kind
);

  logic                four_byte_packets;
  logic                pkt_valid;
  logic                pkt_ready;
  ps2md_pkg::packet_t  pkt;
  ps2md_pkg::result_t  res;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      four_byte_packets <= 1'b0;
    end else if (cfg_wr_en) begin
      four_byte_packets <= cfg_wr_data;
    end
  end

  ps2md_framer u_framer (
    .clk               (clk),
    .rst               (rst),
    .four_byte_packets (four_byte_packets),
    .byte_valid        (s_axis_tvalid),
    .byte_ready        (s_axis_tready),
    .data_byte         (s_axis_tdata),
    .pkt_valid         (pkt_valid),
    .pkt_ready         (pkt_ready),
    .pkt               (pkt)
  );

  ps2md_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .pkt_valid (pkt_valid),
    .pkt_ready (pkt_ready),
    .pkt       (pkt),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  // Pack the result word
  assign m_axis_tdata = {2'b00, res.y_total, res.x_total, res.y_maximum, res.y_minimum,
                         res.x_maximum, res.x_minimum, res.error_bits, res.button_bits,
                         res.delta_y, res.delta_x, res.wheel_delta};
  assign m_axis_tuser = res.packet_kind;

  // Input stalls only when the result register is full and held
  `PS2MD_ASSERT_SAME(a_stall_cause, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "bad stall")
  // Running minima never rise above zero
  `PS2MD_ASSERT_SAME(a_min_x_sign, m_axis_tvalid, res.x_minimum <= 9'sd0, "x minimum above zero")
  `PS2MD_ASSERT_SAME(a_min_y_sign, m_axis_tvalid, res.y_minimum <= 9'sd0, "y minimum above zero")
  // A packet offered while the result register is empty or draining is loaded in the next cycle
  `PS2MD_ASSERT_NEXT(a_pkt_moves, pkt_valid && pkt_ready, m_axis_tvalid, "packet not loaded")

endmodule

`default_nettype wire
